FILE: rtl/stream_inversion_counter_defines.svh
// ----------------------------------------------------------------------------
// stream_inversion_counter_defines.svh
// Assertion macros for the stream inversion counter.
// ----------------------------------------------------------------------------
`ifndef STREAM_INVERSION_COUNTER_DEFINES_SVH
`define STREAM_INVERSION_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define SIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define SIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define SIC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared constants and the token type that walks the cell chain.
// ----------------------------------------------------------------------------
package sic_pkg;

  localparam int MAX_LEN = 256;               // number of cells, 2..4096
  localparam int VAL_W   = 32;
  localparam int CNT_W   = $clog2(MAX_LEN);   // per-item count, up to MAX_LEN-1
  localparam int TOT_W   = 15;
  localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

  // One sequence element in flight along the chain.
  typedef struct packed {
    logic                    vld;     // slot carries an element
    logic                    lst;     // final element of the sequence
    logic                    placed;  // already stored by an earlier cell
    logic signed [VAL_W-1:0] value;
    logic [CNT_W-1:0]        cnt;     // earlier values greater than this one
  } tok_t;

endpackage

FILE: rtl/sic_cell.sv
// ----------------------------------------------------------------------------
// sic_cell
// One chain cell: holds one stored value, counts it against passing elements.
// ----------------------------------------------------------------------------
module sic_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  sic_pkg::tok_t  tok_i,
  output sic_pkg::tok_t  tok_o
);

  logic                             held_vld_r, held_vld_nxt;
  logic signed [sic_pkg::VAL_W-1:0] held_val_r;
  sic_pkg::tok_t                    tok_r, tok_nxt;
  logic                             gt;
  logic                             take;

  assign gt   = held_vld_r && (held_val_r > tok_i.value);
  assign take = tok_i.vld && !tok_i.placed && !held_vld_r;

  always_comb begin
    tok_nxt        = tok_i;
    tok_nxt.cnt    = tok_i.cnt + sic_pkg::CNT_W'(gt);
    tok_nxt.placed = tok_i.placed | take;

    held_vld_nxt = held_vld_r;
    if (tok_i.vld) begin
      // the final element empties the cell for the next sequence
      if (tok_i.lst) begin
        held_vld_nxt = 1'b0;
      end else if (take) begin
        held_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      tok_r.vld  <= 1'b0;
    end else if (adv) begin
      held_vld_r <= held_vld_nxt;
      tok_r      <= tok_nxt;
      if (take) begin
        held_val_r <= tok_i.value;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/sic_tail.sv
// ----------------------------------------------------------------------------
// sic_tail
// End of the chain: saturating total, overflow flag and result register.
// ----------------------------------------------------------------------------
module sic_tail (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  sic_pkg::tok_t              tok_i,
  output logic                       out_valid,
  output logic [sic_pkg::TOT_W-1:0]  out_inversion_count,
  output logic                       out_too_long
);

  logic [sic_pkg::TOT_W-1:0] total_r, total_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r;
  logic [sic_pkg::TOT_W-1:0] out_count_r;
  logic                      out_too_long_r;
  logic [sic_pkg::TOT_W:0]   sum;

  assign sum = {1'b0, total_r} + (sic_pkg::TOT_W + 1)'(tok_i.cnt);

  always_comb begin
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    if (tok_i.placed) begin
      total_nxt = sum[sic_pkg::TOT_W] ? sic_pkg::TOT_MAX : sum[sic_pkg::TOT_W-1:0];
    end else begin
      // no free cell took it: element dropped, not counted
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (tok_i.vld && tok_i.lst) begin
        total_r     <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
        if (tok_i.vld) begin
          total_r <= total_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok_i.vld && tok_i.lst) begin
      out_count_r    <= total_nxt;
      out_too_long_r <= ovf_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_inversion_count = out_count_r;
  assign out_too_long        = out_too_long_r;

endmodule

FILE: rtl/stream_inversion_counter.sv
// ----------------------------------------------------------------------------
// stream_inversion_counter
// Streaming inversion counter built as a systolic row of compare cells.
// ----------------------------------------------------------------------------
// Takes one signed 32-bit element per transfer, a full transfer every clock
// when the result side is not stalled. Each element walks a row of MAX_LEN
// cells, one cell per cycle while the row advances; every cell that holds an
// earlier element of the same sequence bumps the element's count when its
// stored value is greater, and the first empty cell keeps the element. The
// final element of a sequence empties each cell as it passes, so the next
// sequence can follow directly behind it. Elements beyond MAX_LEN find no
// free cell, are not counted, and raise too_long. The result of a sequence
// is registered in the tail once its final element has passed every cell of
// the row. The whole row halts while a finished result waits untaken.
// ----------------------------------------------------------------------------
`include "stream_inversion_counter_defines.svh"

module stream_inversion_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  // element input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_value,
  input  logic                        in_last,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [14:0]                 out_inversion_count,
  output logic                        out_too_long
);

  // chain[k] feeds cell k; chain[MAX_LEN] feeds the tail
  sic_pkg::tok_t                 chain [sic_pkg::MAX_LEN+1];
  sic_pkg::tok_t                 tail_tok;
  logic                          tail_last;
  logic                          adv;

  // Whole row moves unless a result sits untaken in the output register.
  assign adv      = !(out_valid && !out_ready);
  assign in_ready = adv;

  always_comb begin
    chain[0].vld    = in_valid;
    chain[0].lst    = in_last;
    chain[0].placed = 1'b0;
    chain[0].value  = in_value;
    chain[0].cnt    = '0;
  end

  for (genvar k = 0; k < sic_pkg::MAX_LEN; k++) begin : g_cell
    sic_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .tok_i  (chain[k]),
      .tok_o  (chain[k+1])
    );
  end

  assign tail_tok  = chain[sic_pkg::MAX_LEN];
  assign tail_last = adv && tail_tok.vld && tail_tok.lst;

  sic_tail u_tail (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (adv),
    .tok_i               (tail_tok),
    .out_valid           (out_valid),
    .out_inversion_count (out_inversion_count),
    .out_too_long        (out_too_long)
  );

  // A result waiting on the output side stays offered.
  `SIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A final element leaving the row always lands in the result register.
  `SIC_ASSERT_NEXT(a_last_gives_result, clk, rst_n, tail_last, out_valid)

  // A final element that found a full row must show up as too_long.
  `SIC_ASSERT_NEXT(a_drop_flagged, clk, rst_n, tail_last && !tail_tok.placed, out_too_long)

endmodule
